[design/pmmf_pkg.sv]
// Shared constants and types for the phasor magnitude median filter.
`default_nettype none
package pmmf_pkg;
  localparam int unsigned NUM_SIGNALS = 6;
  localparam int unsigned MAX_WINDOW  = 128;
  localparam int unsigned SIG_W       = 3;
  localparam int unsigned SLOT_W      = $clog2(MAX_WINDOW);
  localparam int unsigned MAG_W       = 32;
  localparam int unsigned PH_W        = 16;
  localparam int unsigned WIN_W       = 8;
  localparam int unsigned MASK_W      = 6;
  localparam int unsigned CNT_W       = SLOT_W + 1;
  localparam int unsigned BIT_W       = $clog2(MAG_W);
  localparam int unsigned HIST_DEPTH  = NUM_SIGNALS * MAX_WINDOW;
  localparam int unsigned HADDR_W     = $clog2(HIST_DEPTH);
  localparam int unsigned PADDR_W     = 4;

  localparam logic [WIN_W-1:0]  VOLTAGE_WINDOW_RST = 8'd100;
  localparam logic [WIN_W-1:0]  CURRENT_WINDOW_RST = 8'd32;
  localparam logic [MASK_W-1:0] VOLTAGE_MASK_RST   = 6'd7;

  typedef enum logic [1:0] {
    REG_VOLTAGE_WINDOW = 2'd0,
    REG_CURRENT_WINDOW = 2'd1,
    REG_VOLTAGE_MASK   = 2'd2,
    REG_NONE           = 2'd3
  } reg_idx_e;
endpackage
`default_nettype wire

[design/pmmf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pmmf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[design/phasor_magnitude_median_filter_unit.sv]
// Top level of the phasor magnitude median filter.
// Each item is written to the history, then the window of length w is scanned once per
// magnitude bit, one history read a cycle; an out-of-range signal index skips the
// history and the scan. Items are handled one at a time: input is ready only in idle.
// Reset: asynchronous, active low; registers return to defaults, then a clearing pass
// zeroes all 768 history RAM entries before the first beat is accepted.
`default_nettype none
module phasor_magnitude_median_filter_unit
  import pmmf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [47:0]        s_axis_tdata,  // [31:0] magnitude, [47:32] phase
  input  wire logic [SIG_W-1:0]   s_axis_tuser,  // [2:0] signal_index
  // output stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [47:0]        m_axis_tdata,  // [31:0] filtered_magnitude, [47:32] out_phase
  output logic      [SIG_W-1:0]   m_axis_tuser,  // [2:0] out_signal_index
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [WIN_W-1:0]  vwin_q, cwin_q;
  logic [MASK_W-1:0] vmask_q;
  reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vwin_q  <= VOLTAGE_WINDOW_RST;
      cwin_q  <= CURRENT_WINDOW_RST;
      vmask_q <= VOLTAGE_MASK_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_VOLTAGE_WINDOW: vwin_q  <= pwdata[WIN_W-1:0];
        REG_CURRENT_WINDOW: cwin_q  <= pwdata[WIN_W-1:0];
        REG_VOLTAGE_MASK:   vmask_q <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VOLTAGE_WINDOW: prdata = 32'(vwin_q);
      REG_CURRENT_WINDOW: prdata = 32'(cwin_q);
      REG_VOLTAGE_MASK:   prdata = 32'(vmask_q);
      default:            prdata = '0;
    endcase
  end

  // per-signal write positions (next slot to write)
  logic [SLOT_W-1:0] wpos_q [NUM_SIGNALS];

  // item and selection state
  logic [SIG_W-1:0]   sig_q;
  logic [MAG_W-1:0]   mag_q;
  logic [PH_W-1:0]    ph_q;
  logic [WIN_W-1:0]   w_q;
  logic [SLOT_W-1:0]  base_q;     // slot of the newest entry
  logic [SLOT_W-1:0]  ka_q, kb_q; // remaining ranks of the two middle values
  logic [MAG_W-1:0]   pa_q, pb_q; // resolved prefixes
  logic [CNT_W-1:0]   cnta_q, cntb_q;
  logic [WIN_W-1:0]   idx_q;
  logic [BIT_W-1:0]   bit_q;
  logic               rd_vld_q;
  logic [HADDR_W-1:0] clr_q;

  // output register
  logic             m_valid_q;
  logic [MAG_W-1:0] m_mag_q;
  logic [PH_W-1:0]  m_ph_q;
  logic [SIG_W-1:0] m_sig_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_ph_q, m_mag_q};
  assign m_axis_tuser  = m_sig_q;

  // window length for the incoming beat, clamped to 1..MAX_WINDOW
  logic [SIG_W-1:0] in_sig;
  logic             in_volt;
  logic [WIN_W-1:0] in_wraw, in_w;

  assign in_sig  = s_axis_tuser;
  assign in_volt = (32'(in_sig) < MASK_W) ? vmask_q[in_sig] : 1'b0;
  assign in_wraw = in_volt ? vwin_q : cwin_q;

  always_comb begin
    if (in_wraw == '0) begin
      in_w = WIN_W'(1);
    end else if (32'(in_wraw) > MAX_WINDOW) begin
      in_w = WIN_W'(MAX_WINDOW);
    end else begin
      in_w = in_wraw;
    end
  end

  // history RAM ports
  logic               ram_we;
  logic [HADDR_W-1:0] ram_waddr, ram_raddr;
  logic [MAG_W-1:0]   ram_wdata, ram_rdata;
  logic               issue;
  logic [SLOT_W-1:0]  rd_slot;

  assign issue   = (state_q == ST_SCAN) && (idx_q < w_q);
  assign rd_slot = base_q - idx_q[SLOT_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    if (state_q == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_q == ST_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = HADDR_W'({sig_q, base_q});
      ram_wdata = mag_q;
    end
  end

  assign ram_raddr = HADDR_W'({sig_q, rd_slot});

  pmmf_ram #(
    .WIDTH (MAG_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // radix select: count window entries that share the resolved prefix above the
  // current bit and have a zero at it
  logic [MAG_W-1:0] hi_mask;
  logic             hit_a, hit_b;
  logic             scan_end;
  logic             a_one, b_one;
  logic [MAG_W-1:0] bit_set;
  logic [MAG_W:0]   mid_sum;

  assign hi_mask  = {{(MAG_W-1){1'b1}}, 1'b0} << bit_q;
  assign hit_a    = (((ram_rdata ^ pa_q) & hi_mask) == '0) && !ram_rdata[bit_q];
  assign hit_b    = (((ram_rdata ^ pb_q) & hi_mask) == '0) && !ram_rdata[bit_q];
  assign scan_end = (state_q == ST_SCAN) && (idx_q == w_q) && !rd_vld_q;
  assign a_one    = ({1'b0, ka_q} >= cnta_q);
  assign b_one    = ({1'b0, kb_q} >= cntb_q);
  assign bit_set  = MAG_W'(1) << bit_q;
  assign mid_sum  = {1'b0, pa_q} + {1'b0, pb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
      idx_q     <= '0;
      bit_q     <= '0;
      for (int i = 0; i < NUM_SIGNALS; i++) begin
        wpos_q[i] <= '0;
      end
    end else begin
      // drop the output beat once taken, unless a new one replaces it below
      if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end
      rd_vld_q <= issue;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + HADDR_W'(1);
          if (32'(clr_q) == HIST_DEPTH - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            sig_q <= in_sig;
            mag_q <= s_axis_tdata[MAG_W-1:0];
            ph_q  <= s_axis_tdata[MAG_W +: PH_W];
            if (32'(in_sig) < NUM_SIGNALS) begin
              w_q     <= in_w;
              base_q  <= wpos_q[in_sig];
              ka_q    <= SLOT_W'((in_w - WIN_W'(1)) >> 1);
              kb_q    <= SLOT_W'(in_w >> 1);
              pa_q    <= '0;
              pb_q    <= '0;
              state_q <= ST_WRITE;
            end else begin
              // bypass: median of the pair equals the magnitude itself
              pa_q    <= s_axis_tdata[MAG_W-1:0];
              pb_q    <= s_axis_tdata[MAG_W-1:0];
              state_q <= ST_DONE;
            end
          end
        end
        ST_WRITE: begin
          wpos_q[sig_q] <= base_q + SLOT_W'(1);
          idx_q   <= '0;
          bit_q   <= BIT_W'(MAG_W - 1);
          cnta_q  <= '0;
          cntb_q  <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (issue) begin
            idx_q <= idx_q + WIN_W'(1);
          end
          if (rd_vld_q) begin
            cnta_q <= cnta_q + CNT_W'(hit_a);
            cntb_q <= cntb_q + CNT_W'(hit_b);
          end
          if (scan_end) begin
            // resolve this bit for both ranks
            if (a_one) begin
              pa_q <= pa_q | bit_set;
              ka_q <= ka_q - cnta_q[SLOT_W-1:0];
            end
            if (b_one) begin
              pb_q <= pb_q | bit_set;
              kb_q <= kb_q - cntb_q[SLOT_W-1:0];
            end
            idx_q  <= '0;
            cnta_q <= '0;
            cntb_q <= '0;
            if (bit_q == '0) begin
              state_q <= ST_DONE;
            end else begin
              bit_q <= bit_q - BIT_W'(1);
            end
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_mag_q   <= mid_sum[MAG_W:1];
            m_ph_q    <= ph_q;
            m_sig_q   <= sig_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no beat is taken while the history is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input ready during clearing pass");

  // window counts never exceed the window length
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((32'(cnta_q) <= 32'(w_q)) && (32'(cntb_q) <= 32'(w_q))))
    else $error("window count beyond window length");

  // scanning only happens for a valid signal index
  a_scan_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (32'(sig_q) < NUM_SIGNALS))
    else $error("history read for an invalid signal");

  // the lower rank never resolves above the upper one once the item is done
  a_rank_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (pa_q <= pb_q))
    else $error("middle values out of order");
`endif

endmodule
`default_nettype wire
